FILE: hdl/lr_pkg.sv
// shared constants and codes for the line rasteriser
`timescale 1ns / 1ps

package lr_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int DIM_BITS           = 15;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int ERR_GUARD_BITS     = 4;

    localparam logic [DIM_BITS-1:0] DIM_RESET = 15'd1920;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

endpackage

FILE: hdl/lr_if.sv
// valid/ready channels for endpoint items and emitted pixels
`timescale 1ns / 1ps

interface lr_item_if
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] start_u;
    logic signed [COORD_BITS-1:0] start_v;
    logic signed [COORD_BITS-1:0] end_u;
    logic signed [COORD_BITS-1:0] end_v;

    modport source (output valid, mode, start_u, start_v, end_u, end_v, input ready);
    modport sink   (input valid, mode, start_u, start_v, end_u, end_v, output ready);
endinterface

interface lr_pixel_if
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_u;
    logic signed [COORD_BITS-1:0] pixel_v;
    logic                         inside_image;
    logic                         last_pixel;

    modport source (output valid, pixel_u, pixel_v, inside_image, last_pixel, input ready);
    modport sink   (input valid, pixel_u, pixel_v, inside_image, last_pixel, output ready);
endinterface

FILE: hdl/line_rasterizer.sv
// Bresenham line rasteriser top level: loads endpoints and emits one pixel per step transaction.
// A load transaction sets up the line in the cycle it is accepted and gives no result; each
// step transaction on an active line puts one pixel into the output register at the edge it is
// accepted, so the result appears in the cycle after. The output register lets the block take a
// new transaction every clock while the sink takes pixels, sustaining one pixel per cycle, but a
// pixel left waiting stalls input; the step path is one error-term add and one line-end compare.
`timescale 1ns / 1ps

module line_rasterizer
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    lr_item_if.sink                   item,
    lr_pixel_if.source                pixel,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]       cfg_data
);

    localparam int ERR_BITS = COORD_BITS + ERR_GUARD_BITS;
    localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    logic [DIM_BITS-1:0] image_width_reg;
    logic [DIM_BITS-1:0] image_height_reg;

    logic                         line_active_reg;
    logic                         line_active_next;
    logic                         major_is_u_reg;
    logic                         major_is_u_next;
    logic                         minor_neg_reg;
    logic                         minor_neg_next;
    logic signed [COORD_BITS-1:0] cur_u_reg;
    logic signed [COORD_BITS-1:0] cur_u_next;
    logic signed [COORD_BITS-1:0] cur_v_reg;
    logic signed [COORD_BITS-1:0] cur_v_next;
    logic signed [COORD_BITS-1:0] major_end_reg;
    logic signed [COORD_BITS-1:0] major_end_next;
    logic signed [ERR_BITS-1:0]   error_term_reg;
    logic signed [ERR_BITS-1:0]   error_term_next;
    logic signed [ERR_BITS-1:0]   inc_diag_reg;
    logic signed [ERR_BITS-1:0]   inc_diag_next;
    logic signed [ERR_BITS-1:0]   inc_axial_reg;
    logic signed [ERR_BITS-1:0]   inc_axial_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [COORD_BITS-1:0] pixel_u_reg;
    logic signed [COORD_BITS-1:0] pixel_v_reg;
    logic                         inside_reg;
    logic                         last_reg;

    logic                         setup_major_is_u;
    logic                         setup_minor_neg;
    logic signed [COORD_BITS-1:0] setup_first_u;
    logic signed [COORD_BITS-1:0] setup_first_v;
    logic signed [COORD_BITS-1:0] setup_major_end;
    logic signed [ERR_BITS-1:0]   setup_error;
    logic signed [ERR_BITS-1:0]   setup_inc_diag;
    logic signed [ERR_BITS-1:0]   setup_inc_axial;

    logic                         item_fire;
    logic                         load_fire;
    logic                         step_fire;
    logic signed [COORD_BITS-1:0] cur_major;
    logic signed [COORD_BITS-1:0] cur_minor;
    logic signed [COORD_BITS-1:0] minor_moved;
    logic signed [COORD_BITS-1:0] major_moved;
    logic                         at_last;
    logic                         inside_now;
    logic                         error_pos;

    lr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_u             (item.start_u),
        .start_v             (item.start_v),
        .end_u               (item.end_u),
        .end_v               (item.end_v),
        .major_is_u          (setup_major_is_u),
        .minor_step_negative (setup_minor_neg),
        .first_u             (setup_first_u),
        .first_v             (setup_first_v),
        .major_end           (setup_major_end),
        .error_init          (setup_error),
        .inc_diag            (setup_inc_diag),
        .inc_axial           (setup_inc_axial)
    );

    assign item.ready = !out_valid_reg || pixel.ready;
    assign item_fire  = item.valid && item.ready;
    assign load_fire  = item_fire && (item.mode == MODE_LOAD);
    assign step_fire  = item_fire && (item.mode == MODE_STEP) && line_active_reg;

    // current pixel and one bresenham step
    always_comb
    begin
        cur_major   = major_is_u_reg ? cur_u_reg : cur_v_reg;
        cur_minor   = major_is_u_reg ? cur_v_reg : cur_u_reg;
        at_last     = cur_major >= major_end_reg;
        inside_now  = !cur_u_reg[COORD_BITS-1] && !cur_v_reg[COORD_BITS-1]
                      && (CMP_BITS'(cur_u_reg) < CMP_BITS'(image_width_reg))
                      && (CMP_BITS'(cur_v_reg) < CMP_BITS'(image_height_reg));
        error_pos   = !error_term_reg[ERR_BITS-1] && (error_term_reg != '0);
        minor_moved = minor_neg_reg ? cur_minor - 1'b1 : cur_minor + 1'b1;
        major_moved = cur_major + 1'b1;
    end

    always_comb
    begin
        line_active_next = line_active_reg;
        major_is_u_next  = major_is_u_reg;
        minor_neg_next   = minor_neg_reg;
        cur_u_next       = cur_u_reg;
        cur_v_next       = cur_v_reg;
        major_end_next   = major_end_reg;
        error_term_next  = error_term_reg;
        inc_diag_next    = inc_diag_reg;
        inc_axial_next   = inc_axial_reg;

        priority if (load_fire)
        begin
            line_active_next = 1'b1;
            major_is_u_next  = setup_major_is_u;
            minor_neg_next   = setup_minor_neg;
            cur_u_next       = setup_first_u;
            cur_v_next       = setup_first_v;
            major_end_next   = setup_major_end;
            error_term_next  = setup_error;
            inc_diag_next    = setup_inc_diag;
            inc_axial_next   = setup_inc_axial;
        end
        else if (step_fire && at_last)
        begin
            line_active_next = 1'b0;
        end
        else if (step_fire)
        begin
            error_term_next = error_term_reg + (error_pos ? inc_diag_reg : inc_axial_reg);
            if (major_is_u_reg)
            begin
                cur_u_next = major_moved;
                cur_v_next = error_pos ? minor_moved : cur_v_reg;
            end
            else
            begin
                cur_v_next = major_moved;
                cur_u_next = error_pos ? minor_moved : cur_u_reg;
            end
        end
    end

    always_comb
    begin
        priority if (step_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg <= 1'b0;
            major_is_u_reg  <= 1'b0;
            minor_neg_reg   <= 1'b0;
            cur_u_reg       <= '0;
            cur_v_reg       <= '0;
            major_end_reg   <= '0;
            error_term_reg  <= '0;
            inc_diag_reg    <= '0;
            inc_axial_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            line_active_reg <= line_active_next;
            major_is_u_reg  <= major_is_u_next;
            minor_neg_reg   <= minor_neg_next;
            cur_u_reg       <= cur_u_next;
            cur_v_reg       <= cur_v_next;
            major_end_reg   <= major_end_next;
            error_term_reg  <= error_term_next;
            inc_diag_reg    <= inc_diag_next;
            inc_axial_reg   <= inc_axial_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            pixel_u_reg <= cur_u_reg;
            pixel_v_reg <= cur_v_reg;
            inside_reg  <= inside_now;
            last_reg    <= at_last;
        end
    end

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_u      = pixel_u_reg;
    assign pixel.pixel_v      = pixel_v_reg;
    assign pixel.inside_image = inside_reg;
    assign pixel.last_pixel   = last_reg;

    a_load_activates: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> line_active_reg)
        else $error("line not active after load");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && at_last) |=> !line_active_reg && out_valid_reg && last_reg)
        else $error("line still active after last pixel");

    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (item_fire && (item.mode == MODE_STEP) && !line_active_reg && pixel.ready)
        |=> !out_valid_reg)
        else $error("pixel emitted with no active line");

    a_major_u_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && !at_last && major_is_u_reg)
        |=> cur_u_reg == COORD_BITS'($past(cur_u_reg) + 1'b1))
        else $error("major coordinate u did not advance");

    a_major_v_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && !at_last && !major_is_u_reg)
        |=> cur_v_reg == COORD_BITS'($past(cur_v_reg) + 1'b1))
        else $error("major coordinate v did not advance");

endmodule

FILE: hdl/lr_setup.sv
// line setup: major axis choice, endpoint ordering and initial error terms
`timescale 1ns / 1ps

module lr_setup
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic signed [COORD_BITS-1:0]                start_u,
    input  logic signed [COORD_BITS-1:0]                start_v,
    input  logic signed [COORD_BITS-1:0]                end_u,
    input  logic signed [COORD_BITS-1:0]                end_v,
    output logic                                        major_is_u,
    output logic                                        minor_step_negative,
    output logic signed [COORD_BITS-1:0]                first_u,
    output logic signed [COORD_BITS-1:0]                first_v,
    output logic signed [COORD_BITS-1:0]                major_end,
    output logic signed [COORD_BITS+ERR_GUARD_BITS-1:0] error_init,
    output logic signed [COORD_BITS+ERR_GUARD_BITS-1:0] inc_diag,
    output logic signed [COORD_BITS+ERR_GUARD_BITS-1:0] inc_axial
);

    localparam int ERR_BITS = COORD_BITS + ERR_GUARD_BITS;

    logic signed [COORD_BITS:0]   du;
    logic signed [COORD_BITS:0]   dv;
    logic signed [COORD_BITS:0]   d_minor_raw;
    logic        [COORD_BITS-1:0] abs_du;
    logic        [COORD_BITS-1:0] abs_dv;
    logic        [COORD_BITS-1:0] d_major;
    logic        [COORD_BITS-1:0] d_minor;
    logic signed [COORD_BITS-1:0] maj0;
    logic signed [COORD_BITS-1:0] maj1;
    logic signed [COORD_BITS-1:0] min0;
    logic signed [COORD_BITS-1:0] min1;
    logic signed [COORD_BITS-1:0] first_major;
    logic signed [COORD_BITS-1:0] first_minor;
    logic                         swap;

    always_comb
    begin
        du     = $signed({end_u[COORD_BITS-1], end_u}) - $signed({start_u[COORD_BITS-1], start_u});
        dv     = $signed({end_v[COORD_BITS-1], end_v}) - $signed({start_v[COORD_BITS-1], start_v});
        abs_du = du[COORD_BITS] ? COORD_BITS'(-du) : COORD_BITS'(du);
        abs_dv = dv[COORD_BITS] ? COORD_BITS'(-dv) : COORD_BITS'(dv);

        // ties go to v
        major_is_u = abs_dv < abs_du;

        if (major_is_u)
        begin
            maj0        = start_u;
            maj1        = end_u;
            min0        = start_v;
            min1        = end_v;
            swap        = du[COORD_BITS];
            d_minor_raw = dv;
            d_major     = abs_du;
            d_minor     = abs_dv;
        end
        else
        begin
            maj0        = start_v;
            maj1        = end_v;
            min0        = start_u;
            min1        = end_u;
            swap        = dv[COORD_BITS];
            d_minor_raw = du;
            d_major     = abs_dv;
            d_minor     = abs_du;
        end

        first_major = swap ? maj1 : maj0;
        first_minor = swap ? min1 : min0;
        major_end   = swap ? maj0 : maj1;

        // minor direction flips when the endpoints are swapped
        if (swap)
        begin
            minor_step_negative = !d_minor_raw[COORD_BITS] && (d_minor_raw != '0);
        end
        else
        begin
            minor_step_negative = d_minor_raw[COORD_BITS];
        end

        first_u = major_is_u ? first_major : first_minor;
        first_v = major_is_u ? first_minor : first_major;

        error_init = $signed(ERR_BITS'({d_minor, 1'b0}) - ERR_BITS'(d_major));
        inc_diag   = $signed(ERR_BITS'({d_minor, 1'b0}) - ERR_BITS'({d_major, 1'b0}));
        inc_axial  = $signed(ERR_BITS'({d_minor, 1'b0}));
    end

endmodule
